FILE: rtl/two_channel_frame_deframer_assert.svh
// Assertion macros for the two-channel frame deframer.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef TWO_CHANNEL_FRAME_DEFRAMER_ASSERT_SVH
`define TWO_CHANNEL_FRAME_DEFRAMER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define TCFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tcfd_pkg.sv
// Shared types and constants for the two-channel frame deframer.
// No dependencies.
`default_nettype none

package tcfd_pkg;

  localparam int DEFAULT_MAX_FRAME = 512;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] TYPE08_ID  = 8'h08;
  localparam logic [7:0] TYPE88_ID  = 8'h88;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_D     = 8'h44;

  localparam int TYPE08_LEN = 4;
  localparam int TYPE88_LEN = 13;

  localparam logic [1:0] ALIVE_08 = 2'b01;
  localparam logic [1:0] ALIVE_88 = 2'b10;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_NO_START   = 3'd1;
  localparam logic [2:0] EV_TOO_LONG   = 3'd2;
  localparam logic [2:0] EV_TYPE08     = 3'd3;
  localparam logic [2:0] EV_TYPE88     = 3'd4;
  localparam logic [2:0] EV_UNKNOWN    = 3'd5;

  typedef struct packed {
    logic       channel;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       channel_echo;
    logic [2:0] event_res;
    logic [8:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/two_channel_frame_deframer.sv
// A result is registered from its accepted byte, through the skid stage if the output is stalled.
// Throughput: one byte per cycle while item_stall is low; the per-channel
// parser registers are read and written in the same cycle, and a skid
// stage decouples the sides. Reset (synchronous, active high) puts both
// parsers in start-byte hunt, clears counters and the result/skid stages.
// Depends on tcfd_pkg and two_channel_frame_deframer_assert.svh.
`default_nettype none

module two_channel_frame_deframer #(
  parameter int MAX_FRAME = tcfd_pkg::DEFAULT_MAX_FRAME
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_stall,
  input  tcfd_pkg::item_t    item,
  output logic               result_valid,
  input  wire                result_stall,
  output tcfd_pkg::result_t  result
);

  localparam int CNT_W = $clog2(MAX_FRAME);
  localparam logic [16:0] LEN_LIMIT = 17'(MAX_FRAME);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CSUM   = 3'd4
  } phase_t;

  // per-channel parser state
  phase_t           phase       [2];
  logic [CNT_W-1:0] bytes_left  [2];
  logic [CNT_W-1:0] bytes_seen  [2];
  logic [7:0]       length_high [2];
  logic [1:0]       alive       [2];

  // output register and skid stage
  logic              skid_valid;
  tcfd_pkg::result_t skid;

  logic              accept;
  logic              out_free;
  logic              ch;
  phase_t            phase_next;
  logic [CNT_W-1:0]  bytes_left_next;
  logic [CNT_W-1:0]  bytes_seen_next;
  logic [7:0]        length_high_next;
  logic [1:0]        alive_next;
  tcfd_pkg::result_t res_new;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign ch         = item.channel;

  always_comb begin
    logic [15:0]      len;
    logic [CNT_W-1:0] left_dec;
    logic [1:0]       a;
    logic [7:0]       b;
    logic [CNT_W-1:0] seen;
    logic [CNT_W-1:0] left;

    b    = item.data_byte;
    seen = bytes_seen[ch];
    left = bytes_left[ch];
    len  = {length_high[ch], b};
    a    = alive[ch];
    left_dec = (left != '0) ? left - CNT_W'(1) : left;

    phase_next       = phase[ch];
    bytes_left_next  = left;
    bytes_seen_next  = seen;
    length_high_next = length_high[ch];
    alive_next       = a;
    res_new.channel_echo = ch;
    res_new.event_res    = tcfd_pkg::EV_NONE;
    res_new.frame_length = '0;

    case (phase[ch])
      PH_LEN_HI: begin
        length_high_next = b;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        bytes_seen_next = '0;
        alive_next      = tcfd_pkg::ALIVE_08 | tcfd_pkg::ALIVE_88;
        if ({1'b0, len} >= LEN_LIMIT) begin
          // drop the frame
          res_new.event_res = tcfd_pkg::EV_TOO_LONG;
          bytes_left_next   = '0;
          phase_next        = PH_HUNT;
        end else begin
          bytes_left_next = CNT_W'(len);
          phase_next      = (len == 16'd0) ? PH_CSUM : PH_DATA;
        end
      end
      PH_DATA: begin
        if (seen == CNT_W'(0)) begin
          if (b != tcfd_pkg::TYPE08_ID) a = a & ~tcfd_pkg::ALIVE_08;
          if (b != tcfd_pkg::TYPE88_ID) a = a & ~tcfd_pkg::ALIVE_88;
        end else if (seen == CNT_W'(2)) begin
          if (b != tcfd_pkg::CHAR_I) a = '0;
        end else if (seen == CNT_W'(3)) begin
          if (b != tcfd_pkg::CHAR_D) a = '0;
        end
        alive_next      = a;
        bytes_seen_next = seen + CNT_W'(1);
        bytes_left_next = left_dec;
        if (left_dec == '0) phase_next = PH_CSUM;
      end
      PH_CSUM: begin
        // checksum byte is consumed, not checked
        if (seen == CNT_W'(tcfd_pkg::TYPE08_LEN) && a[0])
          res_new.event_res = tcfd_pkg::EV_TYPE08;
        else if (seen == CNT_W'(tcfd_pkg::TYPE88_LEN) && a[1])
          res_new.event_res = tcfd_pkg::EV_TYPE88;
        else
          res_new.event_res = tcfd_pkg::EV_UNKNOWN;
        res_new.frame_length = 9'(seen);
        phase_next           = PH_HUNT;
      end
      default: begin
        // hunt, including unused phase codes
        if (b != tcfd_pkg::START_BYTE) begin
          res_new.event_res = tcfd_pkg::EV_NO_START;
          phase_next        = PH_HUNT;
        end else begin
          phase_next = PH_LEN_HI;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        phase[i]       <= PH_HUNT;
        bytes_left[i]  <= '0;
        bytes_seen[i]  <= '0;
        length_high[i] <= '0;
        alive[i]       <= tcfd_pkg::ALIVE_08 | tcfd_pkg::ALIVE_88;
      end
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase[ch]       <= phase_next;
        bytes_left[ch]  <= bytes_left_next;
        bytes_seen[ch]  <= bytes_seen_next;
        length_high[ch] <= length_high_next;
        alive[ch]       <= alive_next;
      end
      if (out_free) begin
        // drain the skid stage first; no transaction is accepted while it holds
        if (skid_valid) begin
          result       <= skid;
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end else begin
          result_valid <= accept;
          if (accept) result <= res_new;
        end
      end else if (accept) begin
        skid       <= res_new;
        skid_valid <= 1'b1;
      end
    end
  end

`include "two_channel_frame_deframer_assert.svh"

  `TCFD_ASSERT_SAME(a_skid_behind_out, skid_valid, result_valid,
                    "skid stage full while result register empty")
  `TCFD_ASSERT_NEXT(a_stall_fills_skid, accept && !out_free, skid_valid,
                    "transaction lost while result stalled")
  `TCFD_ASSERT_SAME(a_len_zero_no_frame,
                    result_valid && (result.event_res == tcfd_pkg::EV_NONE ||
                    result.event_res == tcfd_pkg::EV_NO_START ||
                    result.event_res == tcfd_pkg::EV_TOO_LONG),
                    result.frame_length == 9'd0,
                    "frame length set on a non-frame event")
  `TCFD_ASSERT_SAME(a_type08_len,
                    result_valid && result.event_res == tcfd_pkg::EV_TYPE08,
                    result.frame_length == 9'(tcfd_pkg::TYPE08_LEN),
                    "type08 match with wrong length")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for two_channel_frame_deframer: drives bytes on two interleaved
// channels and checks each result against a behavioral frame parser.
// Depends on tcfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAME_LIMIT = tcfd_pkg::DEFAULT_MAX_FRAME;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CHECKSUM
  } parse_phase_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  tcfd_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  tcfd_pkg::result_t result;

  // Per-channel parser state of the predictor
  parse_phase_t lane_phase[2];
  logic [15:0]  remaining[2];
  logic [8:0]   received[2];
  logic [7:0]   len_hi[2];
  logic [1:0]   still_possible[2];

  tcfd_pkg::result_t pending_results[$];
  logic [7:0]        lane0_bytes[$];
  logic [7:0]        lane1_bytes[$];
  int                mismatch_count = 0;
  int                bytes_sent = 0;
  bit                idling_on = 1'b1;

  two_channel_frame_deframer #(
    .MAX_FRAME(FRAME_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic void reset_lanes();
    for (int i = 0; i < 2; i++) begin
      lane_phase[i]     = PH_HUNT;
      remaining[i]      = '0;
      received[i]       = '0;
      len_hi[i]         = '0;
      still_possible[i] = tcfd_pkg::ALIVE_08 | tcfd_pkg::ALIVE_88;
    end
  endfunction

  function automatic tcfd_pkg::result_t deframe_byte(input tcfd_pkg::item_t it);
    logic              ch;
    logic [7:0]        b;
    logic [15:0]       len;
    tcfd_pkg::result_t r;
    ch = it.channel;
    b  = it.data_byte;
    r.channel_echo = ch;
    r.event_res    = tcfd_pkg::EV_NONE;
    r.frame_length = '0;
    case (lane_phase[ch])
      PH_LEN_HI: begin
        len_hi[ch]     = b;
        lane_phase[ch] = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len = {len_hi[ch], b};
        received[ch]       = '0;
        still_possible[ch] = tcfd_pkg::ALIVE_08 | tcfd_pkg::ALIVE_88;
        if (len >= FRAME_LIMIT) begin
          r.event_res    = tcfd_pkg::EV_TOO_LONG;
          remaining[ch]  = '0;
          lane_phase[ch] = PH_HUNT;
        end else begin
          remaining[ch] = len;
          if (len == 0) lane_phase[ch] = PH_CHECKSUM;
          else lane_phase[ch] = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        // Position 0 picks the type, positions 2 and 3 must spell the tag
        if (received[ch] == 0) begin
          if (b != tcfd_pkg::TYPE08_ID) still_possible[ch] &= ~tcfd_pkg::ALIVE_08;
          if (b != tcfd_pkg::TYPE88_ID) still_possible[ch] &= ~tcfd_pkg::ALIVE_88;
        end else if (received[ch] == 2 && b != tcfd_pkg::CHAR_I) begin
          still_possible[ch] = '0;
        end else if (received[ch] == 3 && b != tcfd_pkg::CHAR_D) begin
          still_possible[ch] = '0;
        end
        received[ch] = received[ch] + 1'b1;
        if (remaining[ch] != 0) remaining[ch] = remaining[ch] - 1'b1;
        if (remaining[ch] == 0) lane_phase[ch] = PH_CHECKSUM;
      end
      PH_CHECKSUM: begin
        if (received[ch] == tcfd_pkg::TYPE08_LEN &&
            (still_possible[ch] & tcfd_pkg::ALIVE_08) != 0)
          r.event_res = tcfd_pkg::EV_TYPE08;
        else if (received[ch] == tcfd_pkg::TYPE88_LEN &&
                 (still_possible[ch] & tcfd_pkg::ALIVE_88) != 0)
          r.event_res = tcfd_pkg::EV_TYPE88;
        else
          r.event_res = tcfd_pkg::EV_UNKNOWN;
        r.frame_length = received[ch];
        lane_phase[ch] = PH_HUNT;
      end
      default: begin
        if (b != tcfd_pkg::START_BYTE) r.event_res = tcfd_pkg::EV_NO_START;
        else lane_phase[ch] = PH_LEN_HI;
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input tcfd_pkg::result_t want,
                               input tcfd_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected ch %0d ev %0d len %0d, got ch %0d ev %0d len %0d",
               $time, what, want.channel_echo, want.event_res, want.frame_length,
               got.channel_echo, got.event_res, got.frame_length);
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    tcfd_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result", '0, result);
        end else begin
          want = pending_results.pop_front();
          if (result.channel_echo !== want.channel_echo ||
              result.event_res !== want.event_res ||
              result.frame_length !== want.frame_length)
            flag_mismatch("result mismatch", want, result);
        end
      end
      result_stall <= idling_on && ($urandom_range(99) < 29);
    end
  end

  task automatic send_byte(input logic ch, input logic [7:0] b);
    tcfd_pkg::item_t it;
    it.channel   = ch;
    it.data_byte = b;
    while (idling_on && $urandom_range(99) < 29) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(deframe_byte(it));
    bytes_sent++;
  endtask

  // Hold off the sender until every outstanding result has arrived
  task automatic wait_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void push_lane(input logic ch, input logic [7:0] b);
    if (ch) lane1_bytes.push_back(b);
    else lane0_bytes.push_back(b);
  endfunction

  // Queue one frame, mostly well formed, sometimes corrupted, cut short, oversized or noise
  task automatic build_frame(input logic ch);
    int         kind;
    int         len;
    int         total;
    int         cut;
    logic [7:0] fb[0:31];
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 3)) push_lane(ch, 8'($urandom_range(255)));
    end else if (kind < 16) begin
      len = $urandom_range(FRAME_LIMIT, 65535);
      push_lane(ch, tcfd_pkg::START_BYTE);
      push_lane(ch, len[15:8]);
      push_lane(ch, len[7:0]);
    end else begin
      if (kind < 46) len = tcfd_pkg::TYPE08_LEN;
      else if (kind < 76) len = tcfd_pkg::TYPE88_LEN;
      else len = $urandom_range(0, 20);
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1) == 1) len = len + 1;
        else if (len > 0) len = len - 1;
      end
      total = len + 4;
      fb[0] = tcfd_pkg::START_BYTE;
      fb[1] = 8'(len >> 8);
      fb[2] = 8'(len);
      for (int i = 0; i <= len; i++) fb[3 + i] = 8'($urandom_range(255));
      if (kind < 76 && len > 0) begin
        fb[3] = (kind < 46) ? tcfd_pkg::TYPE08_ID : tcfd_pkg::TYPE88_ID;
        if (len > 2) fb[5] = tcfd_pkg::CHAR_I;
        if (len > 3) fb[6] = tcfd_pkg::CHAR_D;
      end
      if ($urandom_range(9) == 0) fb[$urandom_range(3, total - 1)] = 8'($urandom_range(255));
      cut = total;
      if ($urandom_range(19) == 0) cut = $urandom_range(1, total - 1);
      for (int i = 0; i < cut; i++) push_lane(ch, fb[i]);
    end
  endtask

  // Stray bytes, a zero-length frame and an oversize length on channel 0,
  // interleaved with a type 08 frame on channel 1
  task automatic test_hunt_and_short_frames();
    send_byte(1'b1, tcfd_pkg::START_BYTE);
    send_byte(1'b0, 8'h00);
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'h04);
    send_byte(1'b0, tcfd_pkg::START_BYTE);
    send_byte(1'b1, tcfd_pkg::TYPE08_ID);
    send_byte(1'b0, 8'h00);
    send_byte(1'b1, 8'h5A);
    send_byte(1'b0, 8'h00);
    send_byte(1'b1, tcfd_pkg::CHAR_I);
    send_byte(1'b0, 8'hA5);
    send_byte(1'b1, tcfd_pkg::CHAR_D);
    send_byte(1'b1, 8'hC3);
    send_byte(1'b0, tcfd_pkg::START_BYTE);
    send_byte(1'b0, 8'h02);
    send_byte(1'b0, 8'h00);
  endtask

  task automatic test_type88_frame();
    send_byte(1'b0, tcfd_pkg::START_BYTE);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'(tcfd_pkg::TYPE88_LEN));
    send_byte(1'b0, tcfd_pkg::TYPE88_ID);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, tcfd_pkg::CHAR_I);
    send_byte(1'b0, tcfd_pkg::CHAR_D);
    repeat (tcfd_pkg::TYPE88_LEN - 4) send_byte(1'b0, 8'($urandom_range(255)));
    send_byte(1'b0, 8'h00);
  endtask

  // Largest length below the limit fills the frame length field
  task automatic test_longest_frame();
    send_byte(1'b1, tcfd_pkg::START_BYTE);
    send_byte(1'b1, 8'(((FRAME_LIMIT - 1) >> 8)));
    send_byte(1'b1, 8'(FRAME_LIMIT - 1));
    repeat (FRAME_LIMIT - 1) send_byte(1'b1, 8'($urandom_range(255)));
    send_byte(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic test_random_traffic();
    int   start_count;
    logic ch;
    start_count = bytes_sent;
    while (bytes_sent - start_count < 700) begin
      // quiet window in the middle: no idling on either side
      idling_on = !((bytes_sent - start_count) >= 250 && (bytes_sent - start_count) < 500);
      if (lane0_bytes.size() == 0) build_frame(1'b0);
      if (lane1_bytes.size() == 0) build_frame(1'b1);
      ch = 1'($urandom_range(1));
      if (ch) send_byte(1'b1, lane1_bytes.pop_front());
      else send_byte(1'b0, lane0_bytes.pop_front());
    end
    idling_on = 1'b1;
    while (lane0_bytes.size() != 0) send_byte(1'b0, lane0_bytes.pop_front());
    while (lane1_bytes.size() != 0) send_byte(1'b1, lane1_bytes.pop_front());
  endtask

  initial begin
    reset_lanes();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_hunt_and_short_frames();
    test_type88_frame();
    wait_for_results();
    test_longest_frame();
    wait_for_results();
    test_random_traffic();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tcfd_pkg.sv
rtl/two_channel_frame_deframer.sv
test/tb_top.sv
